// ===== hdl/bbc_pkg.sv =====
// Shared types, constants and saturation helper for the ball box collision step.
// Used by every module of the block but bbc_ram; depends on nothing.

package bbc_pkg;

  localparam int BALLS     = 16;
  localparam int FRAC_BITS = 28;
  localparam int BALL_AW   = (BALLS > 1) ? $clog2(BALLS) : 1;
  localparam int CNT_W     = $clog2(BALLS + 1);
  localparam int IN_W      = 200;
  localparam int OUT_W     = 144;

  localparam logic signed [39:0] ONE_Q   = signed'(40'(1) << FRAC_BITS);
  localparam logic signed [39:0] S32_MAX = 40'sh00_7fff_ffff;
  localparam logic signed [39:0] S32_MIN = -40'sh00_8000_0000;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_STEP = 2'd1,
    OP_READ = 2'd2
  } opcode_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic        [30:0] radius;
    logic signed [31:0] gravity;
  } ball_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RD_ISSUE, S_RD_CAP, S_DONE, S_STEP_END,
    S_WL_RD, S_WL_MOVE, S_WL_EVAL, S_WL_DIV, S_WL_MUL, S_WL_FIN,
    S_PR_RDI, S_PR_RDJ, S_PR_CAPJ, S_PR_DIFF, S_PR_SQX, S_PR_SQY, S_PR_SUM,
    S_PR_SQRT, S_PR_CMP, S_PR_MULX, S_PR_DVXS, S_PR_DIVX, S_PR_MULY,
    S_PR_DVYS, S_PR_DIVY, S_PR_WRI, S_PR_WRJ, S_PR_NEXT
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    if (v > S32_MAX) return S32_MAX[31:0];
    if (v < S32_MIN) return S32_MIN[31:0];
    return v[31:0];
  endfunction

endpackage

// ===== hdl/bbc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Stands alone; no package needed.

module bbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/bbc_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on bbc_pkg for the status struct.

module bbc_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [63:0]         dividend,
  input  logic [32:0]         divisor,
  output bbc_pkg::unit_stat_t stat,
  output logic [63:0]         quotient
);

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [63:0] dvd_r;
  logic [32:0] rem_r;
  logic [32:0] dvs_r;
  logic [33:0] rem_sh;
  logic        ge;
  logic [33:0] rem_sub;

  assign rem_sh  = {rem_r, dvd_r[63]};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = ge ? (rem_sh - {1'b0, dvs_r}) : rem_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[62:0], ge};
      rem_r <= rem_sub[32:0];
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = dvd_r;

endmodule

// ===== hdl/bbc_sqrt.sv =====
// Digit-by-digit integer square root, two radicand bits per cycle.
// Depends on bbc_pkg for the status struct.

module bbc_sqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [63:0]         radicand,
  output bbc_pkg::unit_stat_t stat,
  output logic [31:0]         root
);

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [63:0] v_r;
  logic [33:0] rem_r;
  logic [31:0] root_r;
  logic [35:0] rem_t;
  logic [35:0] trial;
  logic        ge;
  logic [35:0] rem_sub;

  assign rem_t   = {rem_r, v_r[63:62]};
  assign trial   = {2'b00, root_r, 2'b01};
  assign ge      = rem_t >= trial;
  assign rem_sub = ge ? (rem_t - trial) : rem_t;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      v_r    <= {v_r[61:0], 2'b00};
      rem_r  <= rem_sub[33:0];
      root_r <= {root_r[30:0], ge};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign root      = root_r;

endmodule

// ===== hdl/ball_box_collision_step.sv =====
// Top level of the ball box collision step: sequencer, ball memory and datapath.
// Depends on bbc_pkg, bbc_ram, bbc_div and bbc_sqrt.

// The block keeps up to 16 balls (position, velocity, radius, gravity, all
// Q3.28) in one synchronous memory and answers every input transaction with
// exactly one result transaction. A load goes straight to the done state; a
// read passes the issue and capture states first. A step walks the first
// active_count balls through the memory one at a time (move, then walls),
// then walks every pair i<j, reading both balls and writing any change back
// before the next pair is read, so no access ever overlaps another on the
// same entry. A top or bottom wall hit adds a multiply to a ball, and before
// it the hit-time division when the hit comes with a nonzero vertical speed.
// A pair with distinct centres adds two squares and the root; an overlapping
// pair adds two divisions and two write-backs. Walls and pairs share the one
// radix-2 divider. The block takes a new transaction only while its sequencer
// is idle; a finished result sits in the output register while the next
// transaction is accepted. The user must write the active_count register
// through the cfg port only while the block is idle; the block does not
// enforce this. Values above 16 act as 16.

module ball_box_collision_step (
  input  logic                       clk,
  input  logic                       rst_n,
  // in_tdata, from bit 0: ball_index[4], load_x[32], load_y[32], load_vx[32],
  // load_vy[32], load_radius[31], load_gravity[32], zero padding
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [bbc_pkg::IN_W-1:0]   in_tdata,
  // in_tuser: opcode[2]
  input  logic [1:0]                 in_tuser,
  // out_tdata, from bit 0: out_index[4], out_x[32], out_y[32], out_vx[32],
  // out_vy[32], collision_count[8], zero padding
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [bbc_pkg::OUT_W-1:0]  out_tdata,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [4:0]                 cfg_data
);

  localparam int AW = bbc_pkg::BALL_AW;
  localparam int CW = bbc_pkg::CNT_W;

  bbc_pkg::state_t state_r, state_nxt;

  // Configuration and step control.
  logic [4:0]    active_r;
  logic [CW-1:0] n_r, k_r, i_r, j_r;
  logic [CW-1:0] n_cmb;
  logic [7:0]    count_r, last_r;
  logic [3:0]    idx_r;

  // Ball records in flight.
  bbc_pkg::ball_t rec_r, reci_r, recj_r;
  bbc_pkg::ball_t in_ball, ram_rdata, ram_wdata;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr, ram_raddr;

  // Datapath registers.
  logic               qneg_r, tneg_r;
  logic [31:0]        tmag_r;
  logic signed [32:0] dx_r, dy_r;
  logic [31:0]        ax_r, ay_r;
  logic               big_r;
  logic [63:0]        sq_r, prod_r;
  logic [33:0]        dist_r;
  logic [31:0]        half_r, cx_r, cy_r;
  logic [31:0]        mul_a, mul_b;

  // Result registers.
  logic [3:0]         res_idx_r;
  logic signed [31:0] res_x_r, res_y_r, res_vx_r, res_vy_r;
  logic               out_valid_r;
  logic [bbc_pkg::OUT_W-1:0] out_data_r;

  // Shared units.
  logic                div_start, sqrt_start;
  logic [63:0]         div_dvd, div_q, sqrt_rad;
  logic [32:0]         div_dvs;
  logic [31:0]         sqrt_root;
  bbc_pkg::unit_stat_t div_stat, sqrt_stat;

  logic          in_acc;
  logic          out_free;
  logic [3:0]    in_idx;
  logic          in_idx_ok;
  logic          idx_ok;

  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign in_idx    = in_tdata[3:0];
  assign in_idx_ok = 32'(in_idx) < bbc_pkg::BALLS;
  assign idx_ok    = 32'(idx_r) < bbc_pkg::BALLS;
  assign n_cmb     = (32'(active_r) > bbc_pkg::BALLS) ? CW'(bbc_pkg::BALLS) : CW'(active_r);

  always_comb begin
    in_ball.x       = in_tdata[35:4];
    in_ball.y       = in_tdata[67:36];
    in_ball.vx      = in_tdata[99:68];
    in_ball.vy      = in_tdata[131:100];
    in_ball.radius  = in_tdata[162:132];
    in_ball.gravity = in_tdata[194:163];
  end

  bbc_ram #(.WIDTH($bits(bbc_pkg::ball_t)), .DEPTH(bbc_pkg::BALLS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bbc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .stat     (div_stat),
    .quotient (div_q)
  );

  bbc_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (sqrt_rad),
    .stat     (sqrt_stat),
    .root     (sqrt_root)
  );

  // ---------------------------------------------------------------------------
  // Wall handling, evaluated on the moved ball held in rec_r.
  // ---------------------------------------------------------------------------
  logic signed [39:0] x40, y40, vx40, vy40, g40, r40, num, num_mag;
  logic signed [39:0] m40, sm40;
  logic               hit_top, hit_bot, hit_right, hit_left;
  logic [32:0]        vy_mag;
  logic [31:0]        g_mag;
  logic [63:0]        wall_dvd;
  bbc_pkg::ball_t     wall_ball;
  bbc_pkg::ball_t     moved_ball;

  // The ball just read from memory, advanced by its velocity.
  always_comb begin
    moved_ball   = ram_rdata;
    moved_ball.x = bbc_pkg::sat32(40'(ram_rdata.x) + 40'(ram_rdata.vx));
    moved_ball.y = bbc_pkg::sat32(40'(ram_rdata.y) + 40'(ram_rdata.vy));
  end

  always_comb begin
    x40  = 40'(rec_r.x);
    y40  = 40'(rec_r.y);
    vx40 = 40'(rec_r.vx);
    vy40 = 40'(rec_r.vy);
    g40  = 40'(rec_r.gravity);
    r40  = signed'({9'b0, rec_r.radius});

    hit_top   = (y40 + r40) > bbc_pkg::ONE_Q;
    hit_bot   = !hit_top && ((y40 - r40) < -bbc_pkg::ONE_Q);
    hit_right = (x40 + r40) > bbc_pkg::ONE_Q;
    hit_left  = !hit_right && ((x40 - r40) < -bbc_pkg::ONE_Q);

    // Distance to the wall at the start of the frame; divided by vy it gives
    // the time of the hit within the frame.
    num = hit_top ? (bbc_pkg::ONE_Q - (y40 - vy40 + r40))
                  : (-(y40 - vy40 - r40) - bbc_pkg::ONE_Q);
    num_mag  = (num < 0) ? -num : num;
    wall_dvd = 64'(unsigned'(num_mag)) << bbc_pkg::FRAC_BITS;
    vy_mag   = (rec_r.vy < 0) ? 33'(-vy40) : 33'(vy40);
    g_mag    = (rec_r.gravity < 0) ? 32'(-g40) : 32'(g40);

    m40  = signed'(40'(prod_r >> bbc_pkg::FRAC_BITS));
    sm40 = ((rec_r.gravity < 0) != tneg_r) ? -m40 : m40;

    wall_ball = rec_r;
    if (hit_top) begin
      wall_ball.vy = bbc_pkg::sat32(-(vy40 + sm40));
      wall_ball.y  = bbc_pkg::sat32(bbc_pkg::ONE_Q - r40);
    end else if (hit_bot) begin
      wall_ball.vy = bbc_pkg::sat32(-(vy40 - sm40));
      wall_ball.y  = bbc_pkg::sat32(r40 - bbc_pkg::ONE_Q);
    end else begin
      wall_ball.vy = bbc_pkg::sat32(vy40 + g40);
    end
    if (hit_right) begin
      wall_ball.vx = bbc_pkg::sat32(-vx40);
      wall_ball.x  = bbc_pkg::sat32(bbc_pkg::ONE_Q - r40);
    end else if (hit_left) begin
      wall_ball.vx = bbc_pkg::sat32(-vx40);
      wall_ball.x  = bbc_pkg::sat32(r40 - bbc_pkg::ONE_Q);
    end
  end

  // ---------------------------------------------------------------------------
  // Pair handling.
  // ---------------------------------------------------------------------------
  logic signed [32:0] dx_c, dy_c;
  logic [32:0]        ax_c, ay_c;
  logic [31:0]        opx, opy;
  logic [32:0]        rsum;
  logic               pair_skip;
  logic signed [39:0] sx40, sy40;
  bbc_pkg::ball_t     new_i, new_j;

  always_comb begin
    dx_c = 33'(reci_r.x) - 33'(recj_r.x);
    dy_c = 33'(reci_r.y) - 33'(recj_r.y);
    ax_c = (dx_c < 0) ? unsigned'(-dx_c) : unsigned'(dx_c);
    ay_c = (dy_c < 0) ? unsigned'(-dy_c) : unsigned'(dy_c);

    opx  = big_r ? (ax_r >> 1) : ax_r;
    opy  = big_r ? (ay_r >> 1) : ay_r;
    rsum = {2'b0, reci_r.radius} + {2'b0, recj_r.radius};
    pair_skip = (dist_r == '0) || (dist_r >= {1'b0, rsum});

    sx40 = (dx_r < 0) ? -signed'(40'(cx_r)) : signed'(40'(cx_r));
    sy40 = (dy_r < 0) ? -signed'(40'(cy_r)) : signed'(40'(cy_r));

    // Push apart and swap velocities.
    new_i    = reci_r;
    new_i.x  = bbc_pkg::sat32(40'(reci_r.x) + sx40);
    new_i.y  = bbc_pkg::sat32(40'(reci_r.y) + sy40);
    new_i.vx = recj_r.vx;
    new_i.vy = recj_r.vy;
    new_j    = recj_r;
    new_j.x  = bbc_pkg::sat32(40'(recj_r.x) - sx40);
    new_j.y  = bbc_pkg::sat32(40'(recj_r.y) - sy40);
    new_j.vx = reci_r.vx;
    new_j.vy = reci_r.vy;
  end

  // ---------------------------------------------------------------------------
  // Next state.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bbc_pkg::S_IDLE: begin
        if (in_acc) begin
          case (bbc_pkg::opcode_t'(in_tuser))
            bbc_pkg::OP_STEP: begin
              state_nxt = (n_cmb == '0) ? bbc_pkg::S_STEP_END : bbc_pkg::S_WL_RD;
            end
            bbc_pkg::OP_READ: state_nxt = bbc_pkg::S_RD_ISSUE;
            default:          state_nxt = bbc_pkg::S_DONE;
          endcase
        end
      end
      bbc_pkg::S_RD_ISSUE: state_nxt = bbc_pkg::S_RD_CAP;
      bbc_pkg::S_RD_CAP:   state_nxt = bbc_pkg::S_DONE;
      bbc_pkg::S_DONE: begin
        if (out_free) state_nxt = bbc_pkg::S_IDLE;
      end
      bbc_pkg::S_STEP_END: state_nxt = bbc_pkg::S_DONE;
      bbc_pkg::S_WL_RD:    state_nxt = bbc_pkg::S_WL_MOVE;
      bbc_pkg::S_WL_MOVE:  state_nxt = bbc_pkg::S_WL_EVAL;
      bbc_pkg::S_WL_EVAL: begin
        if (hit_top || hit_bot) begin
          state_nxt = (rec_r.vy != '0) ? bbc_pkg::S_WL_DIV : bbc_pkg::S_WL_MUL;
        end else begin
          state_nxt = bbc_pkg::S_WL_FIN;
        end
      end
      bbc_pkg::S_WL_DIV: begin
        if (div_stat.done) state_nxt = bbc_pkg::S_WL_MUL;
      end
      bbc_pkg::S_WL_MUL: state_nxt = bbc_pkg::S_WL_FIN;
      bbc_pkg::S_WL_FIN: begin
        if ({1'b0, k_r} + (CW+1)'(1) == {1'b0, n_r}) begin
          state_nxt = (32'(n_r) < 2) ? bbc_pkg::S_STEP_END : bbc_pkg::S_PR_RDI;
        end else begin
          state_nxt = bbc_pkg::S_WL_RD;
        end
      end
      bbc_pkg::S_PR_RDI:  state_nxt = bbc_pkg::S_PR_RDJ;
      bbc_pkg::S_PR_RDJ:  state_nxt = bbc_pkg::S_PR_CAPJ;
      bbc_pkg::S_PR_CAPJ: state_nxt = bbc_pkg::S_PR_DIFF;
      bbc_pkg::S_PR_DIFF: begin
        state_nxt = (dx_c == '0 && dy_c == '0) ? bbc_pkg::S_PR_NEXT : bbc_pkg::S_PR_SQX;
      end
      bbc_pkg::S_PR_SQX: state_nxt = bbc_pkg::S_PR_SQY;
      bbc_pkg::S_PR_SQY: state_nxt = bbc_pkg::S_PR_SUM;
      bbc_pkg::S_PR_SUM: state_nxt = bbc_pkg::S_PR_SQRT;
      bbc_pkg::S_PR_SQRT: begin
        if (sqrt_stat.done) state_nxt = bbc_pkg::S_PR_CMP;
      end
      bbc_pkg::S_PR_CMP: begin
        state_nxt = pair_skip ? bbc_pkg::S_PR_NEXT : bbc_pkg::S_PR_MULX;
      end
      bbc_pkg::S_PR_MULX: state_nxt = bbc_pkg::S_PR_DVXS;
      bbc_pkg::S_PR_DVXS: state_nxt = bbc_pkg::S_PR_DIVX;
      bbc_pkg::S_PR_DIVX: begin
        if (div_stat.done) state_nxt = bbc_pkg::S_PR_MULY;
      end
      bbc_pkg::S_PR_MULY: state_nxt = bbc_pkg::S_PR_DVYS;
      bbc_pkg::S_PR_DVYS: state_nxt = bbc_pkg::S_PR_DIVY;
      bbc_pkg::S_PR_DIVY: begin
        if (div_stat.done) state_nxt = bbc_pkg::S_PR_WRI;
      end
      bbc_pkg::S_PR_WRI: state_nxt = bbc_pkg::S_PR_WRJ;
      bbc_pkg::S_PR_WRJ: state_nxt = bbc_pkg::S_PR_NEXT;
      bbc_pkg::S_PR_NEXT: begin
        if ({1'b0, j_r} + (CW+1)'(1) < {1'b0, n_r}) begin
          state_nxt = bbc_pkg::S_PR_RDI;
        end else if ({1'b0, i_r} + (CW+1)'(2) < {1'b0, n_r}) begin
          state_nxt = bbc_pkg::S_PR_RDI;
        end else begin
          state_nxt = bbc_pkg::S_STEP_END;
        end
      end
      default: state_nxt = bbc_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Outputs of the sequencer: memory port, multiplier operands, unit starts.
  // ---------------------------------------------------------------------------
  always_comb begin
    in_tready  = (state_r == bbc_pkg::S_IDLE);
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = in_ball;
    ram_raddr  = '0;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    div_dvd    = prod_r;
    div_dvs    = dist_r[32:0];
    sqrt_start = 1'b0;
    sqrt_rad   = sq_r + prod_r;
    case (state_r)
      bbc_pkg::S_IDLE: begin
        ram_we    = in_acc && (in_tuser == bbc_pkg::OP_LOAD) && in_idx_ok;
        ram_waddr = AW'(in_idx);
      end
      bbc_pkg::S_RD_ISSUE: ram_raddr = AW'(idx_r);
      bbc_pkg::S_WL_RD:    ram_raddr = k_r[AW-1:0];
      bbc_pkg::S_WL_EVAL: begin
        div_start = (hit_top || hit_bot) && (rec_r.vy != '0);
        div_dvd   = wall_dvd;
        div_dvs   = vy_mag;
      end
      bbc_pkg::S_WL_MUL: begin
        mul_a = g_mag;
        mul_b = tmag_r;
      end
      bbc_pkg::S_WL_FIN: begin
        ram_we    = 1'b1;
        ram_waddr = k_r[AW-1:0];
        ram_wdata = wall_ball;
      end
      bbc_pkg::S_PR_RDI: ram_raddr = i_r[AW-1:0];
      bbc_pkg::S_PR_RDJ: ram_raddr = j_r[AW-1:0];
      bbc_pkg::S_PR_SQX: begin
        mul_a = opx;
        mul_b = opx;
      end
      bbc_pkg::S_PR_SQY: begin
        mul_a = opy;
        mul_b = opy;
      end
      bbc_pkg::S_PR_SUM:  sqrt_start = 1'b1;
      bbc_pkg::S_PR_MULX: begin
        mul_a = ax_r;
        mul_b = half_r;
      end
      bbc_pkg::S_PR_DVXS: div_start = 1'b1;
      bbc_pkg::S_PR_MULY: begin
        mul_a = ay_r;
        mul_b = half_r;
      end
      bbc_pkg::S_PR_DVYS: div_start = 1'b1;
      bbc_pkg::S_PR_WRI: begin
        ram_we    = 1'b1;
        ram_waddr = i_r[AW-1:0];
        ram_wdata = new_i;
      end
      bbc_pkg::S_PR_WRJ: begin
        ram_we    = 1'b1;
        ram_waddr = j_r[AW-1:0];
        ram_wdata = new_j;
      end
      default: ;
    endcase
  end

  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------------------
  // Control registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bbc_pkg::S_IDLE;
      active_r    <= '0;
      last_r      <= '0;
      count_r     <= '0;
      n_r         <= '0;
      k_r         <= '0;
      i_r         <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        active_r <= cfg_data;
      end
      case (state_r)
        bbc_pkg::S_IDLE: begin
          if (in_acc) begin
            n_r     <= n_cmb;
            k_r     <= '0;
            count_r <= '0;
          end
        end
        bbc_pkg::S_WL_FIN: begin
          k_r <= k_r + CW'(1);
          i_r <= '0;
          j_r <= CW'(1);
        end
        bbc_pkg::S_PR_WRJ: begin
          if (count_r != 8'hFF) count_r <= count_r + 8'd1;
        end
        bbc_pkg::S_PR_NEXT: begin
          if ({1'b0, j_r} + (CW+1)'(1) < {1'b0, n_r}) begin
            j_r <= j_r + CW'(1);
          end else begin
            i_r <= i_r + CW'(1);
            j_r <= i_r + CW'(2);
          end
        end
        bbc_pkg::S_STEP_END: last_r <= count_r;
        default: ;
      endcase
      if (state_r == bbc_pkg::S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
    case (state_r)
      bbc_pkg::S_IDLE: begin
        idx_r     <= in_idx;
        res_idx_r <= '0;
        res_x_r   <= '0;
        res_y_r   <= '0;
        res_vx_r  <= '0;
        res_vy_r  <= '0;
      end
      bbc_pkg::S_RD_CAP: begin
        res_idx_r <= idx_r;
        res_x_r   <= idx_ok ? ram_rdata.x  : '0;
        res_y_r   <= idx_ok ? ram_rdata.y  : '0;
        res_vx_r  <= idx_ok ? ram_rdata.vx : '0;
        res_vy_r  <= idx_ok ? ram_rdata.vy : '0;
      end
      bbc_pkg::S_WL_MOVE: rec_r <= moved_ball;
      bbc_pkg::S_WL_EVAL: begin
        qneg_r <= (num < 0) != (rec_r.vy < 0);
        tneg_r <= 1'b0;
        tmag_r <= '0;
      end
      bbc_pkg::S_WL_DIV: begin
        if (div_stat.done) begin
          tneg_r <= qneg_r;
          if (qneg_r) begin
            tmag_r <= (div_q >= 64'h8000_0000) ? 32'h8000_0000 : div_q[31:0];
          end else begin
            tmag_r <= (div_q >= 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_q[31:0];
          end
        end
      end
      bbc_pkg::S_PR_RDJ:  reci_r <= ram_rdata;
      bbc_pkg::S_PR_CAPJ: recj_r <= ram_rdata;
      bbc_pkg::S_PR_DIFF: begin
        dx_r  <= dx_c;
        dy_r  <= dy_c;
        ax_r  <= ax_c[31:0];
        ay_r  <= ay_c[31:0];
        big_r <= ax_c[31] || ay_c[31];
      end
      bbc_pkg::S_PR_SQY: sq_r <= prod_r;
      bbc_pkg::S_PR_SQRT: begin
        if (sqrt_stat.done) begin
          dist_r <= big_r ? {1'b0, sqrt_root, 1'b0} : {2'b00, sqrt_root};
        end
      end
      bbc_pkg::S_PR_CMP: half_r <= 32'(({1'b0, rsum} - dist_r) >> 1);
      bbc_pkg::S_PR_DIVX: begin
        if (div_stat.done) cx_r <= div_q[31:0];
      end
      bbc_pkg::S_PR_DIVY: begin
        if (div_stat.done) cy_r <= div_q[31:0];
      end
      bbc_pkg::S_DONE: begin
        if (out_free) begin
          out_data_r <= {4'b0, last_r, res_vy_r, res_vx_r, res_y_r, res_x_r, res_idx_r};
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef ASSERT_OFF
  // The shared divider is only started when it is free.
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // The root unit is only started when it is free.
  a_sqrt_free: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_start |-> !sqrt_stat.busy)
    else $error("root unit started while busy");

  // During the pair walk both indices stay ordered and inside the active set.
  a_pair_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r >= bbc_pkg::S_PR_RDI && state_r <= bbc_pkg::S_PR_NEXT)
      |-> (i_r < j_r) && (j_r < n_r))
    else $error("pair indices out of order");

  // A finished transaction that finds the output free is presented next cycle.
  a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bbc_pkg::S_DONE && out_free)
      |=> (out_tvalid && state_r == bbc_pkg::S_IDLE))
    else $error("result not presented");
`endif

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for ball_box_collision_step: stream driver, monitor and a
// cycle-free predictor of the ball store. Depends on bbc_pkg and the block's RTL.

module tb_top;

  localparam longint     ONE_FX     = longint'(1) << 28;
  localparam int         IDLE_LIMIT = 200000;
  localparam int         IN_SPAN    = 241591910;  // about 0.9 in Q3.28
  localparam logic [1:0] OP_SPARE   = 2'd3;       // opcode without a function

  // One input transaction, in the field order of in_tdata.
  typedef struct {
    logic [1:0]  op;
    logic [3:0]  idx;
    logic [31:0] x, y, vx, vy;
    logic [30:0] radius;
    logic [31:0] grav;
  } ball_cmd_t;

  // One result transaction.
  typedef struct packed {
    logic [3:0]  idx;
    logic [31:0] x, y, vx, vy;
    logic [7:0]  hits;
  } ball_reply_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  logic [bbc_pkg::IN_W-1:0]   in_tdata = '0;
  logic [1:0]                 in_tuser = 2'b00;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [bbc_pkg::OUT_W-1:0]  out_tdata;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [4:0]                 cfg_data = 5'd0;

  ball_box_collision_step i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial forever #5 clk = ~clk;

  // Shadow copy of the ball store and the active count.
  int          sh_x[bbc_pkg::BALLS], sh_y[bbc_pkg::BALLS], sh_vx[bbc_pkg::BALLS];
  int          sh_vy[bbc_pkg::BALLS], sh_g[bbc_pkg::BALLS];
  int unsigned sh_r[bbc_pkg::BALLS];
  int unsigned sh_hits = 0;
  int unsigned sh_active = 0;

  ball_cmd_t   pending_cmds[$];
  ball_reply_t expected_replies[$];
  ball_cmd_t   cmd_on_bus;
  int          queued_count = 0;
  int          sent_count = 0;
  int          replies_seen = 0;
  int          mismatches = 0;
  int          tx_gap = 0;
  int          rx_gap = 0;
  int          hold_left = 0;
  int          idle_cycles = 0;

  function automatic int clamp_s32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return int'(v);
  endfunction

  function automatic longint unsigned abs64(longint v);
    return (v < 0) ? longint'(0) - v : v;
  endfunction

  // Fixed-point product, truncated toward zero.
  function automatic longint fx_mul(longint a, longint b);
    longint unsigned m;
    m = (abs64(a) * abs64(b)) >> 28;
    if (m > 64'h7fffffffffffffff) m = 64'h7fffffffffffffff;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  // Fixed-point quotient, saturated; zero for a zero divisor.
  function automatic int fx_div(longint a, longint b);
    longint unsigned ua, ub, q;
    ua = abs64(a);
    ub = abs64(b);
    if (b == 0) return 0;
    if ((ua >> 35) != 0) q = 64'd1 << 40;
    else q = (ua << 28) / ub;
    if (q > (64'd1 << 40)) q = 64'd1 << 40;
    return clamp_s32(((a < 0) != (b < 0)) ? -longint'(q) : longint'(q));
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Wall handling for one ball; the top wall beats the bottom, the right beats the left.
  function automatic void bounce_walls(int i);
    longint x, y, r, g, vy0;
    int t;
    x = sh_x[i]; y = sh_y[i]; r = sh_r[i]; g = sh_g[i]; vy0 = sh_vy[i];
    if (y + r > ONE_FX) begin
      t = fx_div(ONE_FX - (y - vy0 + r), vy0);
      sh_vy[i] = clamp_s32(-(vy0 + fx_mul(g, t)));
      sh_y[i] = clamp_s32(ONE_FX - r);
    end else if (y - r < -ONE_FX) begin
      t = fx_div(-(y - vy0 - r) - ONE_FX, vy0);
      sh_vy[i] = clamp_s32(-(vy0 - fx_mul(g, t)));
      sh_y[i] = clamp_s32(-ONE_FX + r);
    end else begin
      sh_vy[i] = clamp_s32(vy0 + g);
    end
    if (x + r > ONE_FX) begin
      sh_vx[i] = clamp_s32(-longint'(sh_vx[i]));
      sh_x[i] = clamp_s32(ONE_FX - r);
    end else if (x - r < -ONE_FX) begin
      sh_vx[i] = clamp_s32(-longint'(sh_vx[i]));
      sh_x[i] = clamp_s32(-ONE_FX + r);
    end
  endfunction

  // Pairwise pass in order i<j; returns the saturated collision count.
  function automatic int unsigned resolve_pairs(int n);
    int unsigned cnt;
    longint dx, dy, rsum, sx, sy;
    longint unsigned ax, ay, span, half, cx, cy;
    int t;
    cnt = 0;
    for (int i = 0; i < n; i++) begin
      for (int j = i + 1; j < n; j++) begin
        dx = longint'(sh_x[i]) - sh_x[j];
        dy = longint'(sh_y[i]) - sh_y[j];
        ax = abs64(dx);
        ay = abs64(dy);
        rsum = longint'(sh_r[i]) + longint'(sh_r[j]);
        if (ax == 0 && ay == 0) continue;
        if (ax >= (64'd1 << 31) || ay >= (64'd1 << 31))
          span = int_sqrt((ax >> 1) * (ax >> 1) + (ay >> 1) * (ay >> 1)) << 1;
        else
          span = int_sqrt(ax * ax + ay * ay);
        if (span == 0 || longint'(span) >= rsum) continue;
        half = (longint'(rsum) - span) >> 1;
        cx = (ax * half) / span;
        cy = (ay * half) / span;
        sx = (dx < 0) ? -longint'(cx) : longint'(cx);
        sy = (dy < 0) ? -longint'(cy) : longint'(cy);
        sh_x[i] = clamp_s32(longint'(sh_x[i]) + sx);
        sh_y[i] = clamp_s32(longint'(sh_y[i]) + sy);
        sh_x[j] = clamp_s32(longint'(sh_x[j]) - sx);
        sh_y[j] = clamp_s32(longint'(sh_y[j]) - sy);
        t = sh_vx[i]; sh_vx[i] = sh_vx[j]; sh_vx[j] = t;
        t = sh_vy[i]; sh_vy[i] = sh_vy[j]; sh_vy[j] = t;
        if (cnt < 255) cnt++;
      end
    end
    return cnt;
  endfunction

  // Applies one accepted command to the shadow store and returns its reply.
  function automatic ball_reply_t apply_cmd(ball_cmd_t c);
    ball_reply_t rep;
    int n;
    rep = '{idx: 4'd0, x: 32'd0, y: 32'd0, vx: 32'd0, vy: 32'd0, hits: 8'd0};
    if (c.op == bbc_pkg::OP_LOAD) begin
      sh_x[c.idx] = c.x;  sh_y[c.idx] = c.y;
      sh_vx[c.idx] = c.vx; sh_vy[c.idx] = c.vy;
      sh_r[c.idx] = 32'(c.radius); sh_g[c.idx] = c.grav;
    end else if (c.op == bbc_pkg::OP_STEP) begin
      n = (sh_active > bbc_pkg::BALLS) ? bbc_pkg::BALLS : sh_active;
      for (int k = 0; k < n; k++) begin
        sh_x[k] = clamp_s32(longint'(sh_x[k]) + sh_vx[k]);
        sh_y[k] = clamp_s32(longint'(sh_y[k]) + sh_vy[k]);
      end
      for (int k = 0; k < n; k++) bounce_walls(k);
      sh_hits = resolve_pairs(n);
    end else if (c.op == bbc_pkg::OP_READ) begin
      rep.idx = c.idx;
      rep.x = sh_x[c.idx]; rep.y = sh_y[c.idx];
      rep.vx = sh_vx[c.idx]; rep.vy = sh_vy[c.idx];
    end
    rep.hits = sh_hits[7:0];
    return rep;
  endfunction

  function automatic ball_cmd_t make_cmd(logic [1:0] op, logic [3:0] idx);
    ball_cmd_t c;
    c = '{op: op, idx: idx, x: '0, y: '0, vx: '0, vy: '0, radius: '0, grav: '0};
    return c;
  endfunction

  // A load with in-box content, or with every bit random.
  function automatic ball_cmd_t rand_load(logic [3:0] idx, bit wild);
    ball_cmd_t c;
    c = make_cmd(bbc_pkg::OP_LOAD, idx);
    if (wild) begin
      c.x = $urandom; c.y = $urandom; c.vx = $urandom; c.vy = $urandom;
      c.radius = 31'($urandom); c.grav = $urandom;
    end else begin
      c.x = int'($urandom_range(0, 2 * IN_SPAN)) - IN_SPAN;
      c.y = int'($urandom_range(0, 2 * IN_SPAN)) - IN_SPAN;
      c.vx = int'($urandom_range(0, 1 << 25)) - (1 << 24);
      c.vy = int'($urandom_range(0, 1 << 25)) - (1 << 24);
      c.radius = 31'($urandom_range(1 << 22, 1 << 26));
      c.grav = int'($urandom_range(0, 1 << 21)) - (1 << 20);
    end
    return c;
  endfunction

  // Queues one item for the sender and counts it.
  function automatic void queue_cmd(ball_cmd_t c);
    pending_cmds.push_back(c);
    queued_count++;
  endfunction

  // Sender: one item at a time, random gaps but none in every third run of 50.
  always @(posedge clk) begin
    ball_cmd_t c;
    ball_reply_t rep;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        rep = apply_cmd(cmd_on_bus);
        expected_replies.push_back(rep);
        sent_count++;
      end
      if (!in_tvalid || in_tready) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          c = pending_cmds.pop_front();
          cmd_on_bus = c;
          in_tdata <= {5'd0, c.grav, c.radius, c.vy, c.vx, c.y, c.x, c.idx};
          in_tuser <= c.op;
          in_tvalid <= 1'b1;
          tx_gap <= (((sent_count / 50) % 3) == 0) ? 0 : $urandom_range(0, 17);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks every result transaction and stalls at random. After the
  // 150th result it holds off for a long stretch so the block backs up.
  always @(posedge clk) begin
    ball_reply_t want;
    ball_reply_t got;
    int gap;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_gap <= 0;
      hold_left <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = '{idx: out_tdata[3:0], x: out_tdata[35:4], y: out_tdata[67:36],
                vx: out_tdata[99:68], vy: out_tdata[131:100], hits: out_tdata[139:132]};
        replies_seen++;
        if (expected_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transaction: %p", got);
        end else begin
          want = expected_replies.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d mismatch: expected %p, got %p", replies_seen, want, got);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (out_tvalid && out_tready && replies_seen == 150) begin
        hold_left <= 400;
        out_tready <= 1'b0;
      end else if (out_tvalid && out_tready) begin
        gap = (((replies_seen / 40) % 3) == 1) ? 0 : $urandom_range(0, 17);
        rx_gap <= gap;
        out_tready <= (gap == 0);
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        out_tready <= (rx_gap == 1);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: even a step over all 16 balls stays within the idle limit.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", expected_replies.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Blocks until every queued item has been accepted and answered.
  task automatic drain();
    while (sent_count != queued_count || expected_replies.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes active_count while the block is idle.
  task automatic write_active(logic [4:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sh_active = v;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int phase_counts[] = '{2, 3, 31, 1, 4, 17, 8, 2, 5, 16, 0, 3, 6};
    ball_cmd_t c;
    int pick;
    int step_pct;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: fill every entry so no read or step touches an unwritten ball.
    write_active(5'd0);
    for (int k = 0; k < bbc_pkg::BALLS; k++) queue_cmd(rand_load(4'(k), 1'b0));
    queue_cmd(make_cmd(OP_SPARE, 4'd5));
    queue_cmd(make_cmd(bbc_pkg::OP_STEP, 4'd0));   // step with no active ball
    queue_cmd(make_cmd(bbc_pkg::OP_READ, 4'd15));
    drain();

    // Extreme balls: a radius that hits both vertical and both horizontal walls,
    // zero vertical speed, the most negative velocity, and far-apart centres.
    write_active(5'd4);
    c = make_cmd(bbc_pkg::OP_LOAD, 4'd0);
    c.x = 32'h7fffffff; c.y = 32'h80000000; c.vx = 32'h80000000; c.vy = 32'd0;
    c.radius = 31'h7fffffff; c.grav = 32'h80000000;
    queue_cmd(c);
    c = make_cmd(bbc_pkg::OP_LOAD, 4'd1);
    c.x = 32'h80000000; c.y = 32'h7fffffff; c.vx = 32'h7fffffff; c.vy = 32'h80000000;
    c.radius = 31'd0; c.grav = 32'h7fffffff;
    queue_cmd(c);
    c = make_cmd(bbc_pkg::OP_LOAD, 4'd2);                   // coincident with ball 3
    c.radius = 31'd1 << 26;
    queue_cmd(c);
    c.idx = 4'd3;
    queue_cmd(c);
    queue_cmd(make_cmd(bbc_pkg::OP_STEP, 4'd0));
    for (int k = 0; k < 4; k++) queue_cmd(make_cmd(bbc_pkg::OP_READ, 4'(k)));
    drain();

    // Random phases, each under its own active count. The sender pauses at every
    // phase boundary until all results are back.
    foreach (phase_counts[p]) begin
      write_active(5'(phase_counts[p]));
      step_pct = (phase_counts[p] >= 8) ? 8 : 25;
      for (int k = 0; k < 29; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < step_pct)
          c = make_cmd(bbc_pkg::OP_STEP, 4'($urandom));
        else if (pick < 60)
          c = rand_load(4'($urandom), $urandom_range(0, 4) == 0);
        else if (pick < 95)
          c = make_cmd(bbc_pkg::OP_READ, 4'($urandom));
        else
          c = make_cmd(OP_SPARE, 4'($urandom));
        queue_cmd(c);
      end
      drain();
    end

    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_replies.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
